// File: src/nonce_replay_table_defines.svh
// ----------------------------------------------------------------------------
// nonce replay table assertion macros
// shared concurrent assertion forms, clocked on clk with synchronous reset rst
// ----------------------------------------------------------------------------
`ifndef NONCE_REPLAY_TABLE_DEFINES_SVH
`define NONCE_REPLAY_TABLE_DEFINES_SVH

// same-cycle implication
`define NRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define NRT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: src/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg
// shared sizes, codes and types of the nonce replay table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int STAMP_BITS  = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int NONCE_W    = 64;
  localparam int EXPIRY_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int KIND_W     = 2;
  localparam int REMOVED_W  = 5;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd300;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXPIRED   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAVE    = 2'd0,
    KIND_VERIFY  = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_CLEANUP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [NONCE_W-1:0]    nonce_high;
    logic [NONCE_W-1:0]    nonce_low;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  // result of one pass through the shared compare unit
  typedef struct packed {
    logic match;
    logic stale;
  } cmp_t;

endpackage

// File: src/nrt_in_if.sv
// ----------------------------------------------------------------------------
// nrt_in_if
// request channel: kind and 128-bit nonce with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nrt_in_if import nrt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [NONCE_W-1:0]   nonce_high;
  logic [NONCE_W-1:0]   nonce_low;

  modport source (output valid, kind, nonce_high, nonce_low, input ready);
  modport sink   (input valid, kind, nonce_high, nonce_low, output ready);
endinterface

// File: src/nrt_out_if.sv
// ----------------------------------------------------------------------------
// nrt_out_if
// response channel: status, verified flag and cleanup count with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nrt_out_if import nrt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 verified;
  logic [REMOVED_W-1:0] removed_count;

  modport source (output valid, status, verified, removed_count, input ready);
  modport sink   (input valid, status, verified, removed_count, output ready);
endinterface

// File: src/nrt_cmp_unit.sv
// ----------------------------------------------------------------------------
// nrt_cmp_unit
// shared compare unit: nonce equality and age-versus-expiry test of one entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrt_cmp_unit import nrt_pkg::*; (
  input  entry_t                entry,
  input  logic [NONCE_W-1:0]    nonce_high,
  input  logic [NONCE_W-1:0]    nonce_low,
  input  logic [STAMP_BITS-1:0] seconds_now,
  input  logic [EXPIRY_W-1:0]   expiry,
  output cmp_t                  result
);

  logic [STAMP_BITS-1:0] age;

  // age wraps modulo the stamp width
  assign age = seconds_now - entry.stamp;

  assign result.match = (entry.nonce_high == nonce_high) && (entry.nonce_low == nonce_low);
  assign result.stale = age > STAMP_BITS'(expiry);

endmodule

// File: src/nonce_replay_table.sv
// sequence: save, verify and cleanup pass from accept through a scan of every entry,
//   the apply state and the done state to the result beat; a tick goes straight to done
// throughput: one request at a time, the next beat is taken once the result
//   is loaded; the rate is set by the single compare unit seeing one entry a cycle
// reset: synchronous, clears valid bits, second counter and channel state and
//   loads expiry with 300; nonce and stamp storage is left unwritten
// ----------------------------------------------------------------------------
// nonce_replay_table
// replay cache of 128-bit nonces with per-entry second stamps and expiry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nonce_replay_table_defines.svh"

module nonce_replay_table import nrt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [EXPIRY_W-1:0] cfg_wr_data,
  nrt_in_if.sink              req,
  nrt_out_if.source           rsp
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // sequencer
  state_t state, state_next;

  // configuration and time base
  logic [EXPIRY_W-1:0]   expiry;
  logic [STAMP_BITS-1:0] seconds_now;

  // table storage: payload in plain registers, valid bits with reset
  entry_t                 entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;

  // captured request
  kind_t              kind_r;
  logic [NONCE_W-1:0] hi_r;
  logic [NONCE_W-1:0] lo_r;

  // scan bookkeeping
  logic [IDX_W-1:0]     idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic                 hit_stale;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [REMOVED_W-1:0] removed;

  // finished result waiting for the output register
  logic [STATUS_W-1:0]  res_status;
  logic                 res_verified;
  logic [REMOVED_W-1:0] res_removed;

  // output register
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_verified;
  logic [REMOVED_W-1:0] out_removed;

  logic       accept;
  logic       load_out;
  logic       cur_valid;
  logic       hit_now;
  cmp_t       cmp;
  kind_t      req_kind;
  logic [IDX_W-1:0] wr_idx;

  assign req_kind = kind_t'(req.kind);
  assign accept   = req.valid && req.ready;
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  // one entry per cycle through the shared compare unit
  nrt_cmp_unit u_cmp (
    .entry       (entries[idx]),
    .nonce_high  (hi_r),
    .nonce_low   (lo_r),
    .seconds_now (seconds_now),
    .expiry      (expiry),
    .result      (cmp)
  );

  assign cur_valid = valid[idx];
  assign hit_now   = cur_valid && cmp.match;

  // save goes to the matching slot, otherwise the lowest free one
  assign wr_idx = hit_found ? hit_idx : free_idx;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          // a tick has nothing to scan
          state_next = (req_kind == KIND_TICK) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // expiry register and second counter
  always_ff @(posedge clk) begin
    if (rst) begin
      expiry      <= EXPIRY_RESET;
      seconds_now <= '0;
    end else begin
      if (cfg_wr_en) begin
        expiry <= cfg_wr_data;
      end
      if (accept && req_kind == KIND_TICK) begin
        seconds_now <= seconds_now + STAMP_BITS'(1);
      end
    end
  end

  // request capture and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      removed    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx        <= '0;
          hit_found  <= 1'b0;
          free_found <= 1'b0;
          removed    <= '0;
        end
        S_SCAN: begin
          idx <= idx + IDX_W'(1);
          if ((kind_r == KIND_SAVE || kind_r == KIND_VERIFY) && hit_now && !hit_found) begin
            hit_found <= 1'b1;
          end
          if (kind_r == KIND_SAVE && !cur_valid && !free_found) begin
            free_found <= 1'b1;
          end
          // saturating count of dropped entries
          if (kind_r == KIND_CLEANUP && cur_valid && cmp.stale && removed != '1) begin
            removed <= removed + REMOVED_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload side of the scan, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= req_kind;
      hi_r   <= req.nonce_high;
      lo_r   <= req.nonce_low;
    end
    if (state == S_SCAN) begin
      if (hit_now && !hit_found) begin
        hit_idx   <= idx;
        hit_stale <= cmp.stale;
      end
      if (!cur_valid && !free_found) begin
        free_idx <= idx;
      end
    end
  end

  // valid bits: cleanup drops during the scan, save and verify at apply
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (state == S_SCAN && kind_r == KIND_CLEANUP && cur_valid && cmp.stale) begin
        valid[idx] <= 1'b0;
      end
      if (state == S_APPLY) begin
        if (kind_r == KIND_SAVE && (hit_found || free_found)) begin
          valid[wr_idx] <= 1'b1;
        end
        if (kind_r == KIND_VERIFY && hit_found) begin
          valid[hit_idx] <= 1'b0;
        end
      end
    end
  end

  // entry write on save, restamp in place when already present
  always_ff @(posedge clk) begin
    if (state == S_APPLY && kind_r == KIND_SAVE && (hit_found || free_found)) begin
      entries[wr_idx].nonce_high <= hi_r;
      entries[wr_idx].nonce_low  <= lo_r;
      entries[wr_idx].stamp      <= seconds_now;
    end
  end

  // result forming
  always_ff @(posedge clk) begin
    if (accept && req_kind == KIND_TICK) begin
      res_status   <= STATUS_OK;
      res_verified <= 1'b0;
      res_removed  <= '0;
    end else if (state == S_APPLY) begin
      res_status   <= STATUS_OK;
      res_verified <= 1'b0;
      res_removed  <= '0;
      case (kind_r)
        KIND_SAVE: begin
          if (!hit_found && !free_found) begin
            res_status <= STATUS_FULL;
          end
        end
        KIND_VERIFY: begin
          if (!hit_found) begin
            res_status <= STATUS_NOT_FOUND;
          end else if (hit_stale) begin
            res_status <= STATUS_EXPIRED;
          end else begin
            res_verified <= 1'b1;
          end
        end
        KIND_CLEANUP: begin
          res_removed <= removed;
        end
        default: begin
        end
      endcase
    end
  end

  // output register, holds the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status   <= res_status;
      out_verified <= res_verified;
      out_removed  <= res_removed;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.verified      = out_verified;
  assign rsp.removed_count = out_removed;

  // a verified beat always reports ok
  `NRT_ASSERT_IMP(a_verified_ok, rsp.valid && rsp.verified, rsp.status == STATUS_OK)
  // a tick moves the second counter by exactly one
  `NRT_ASSERT_NXT(a_tick_step, accept && req_kind == KIND_TICK,
                  seconds_now == STAMP_BITS'($past(seconds_now) + STAMP_BITS'(1)))
  // a table request starts its scan at entry zero with nothing found
  `NRT_ASSERT_NXT(a_scan_start, accept && req_kind != KIND_TICK,
                  state == S_SCAN && idx == '0 && !hit_found && !free_found)
  // cleanup count never exceeds the table size
  `NRT_ASSERT_IMP(a_removed_bound, state == S_APPLY,
                  32'(removed) <= 32'(TABLE_DEPTH))

endmodule
